// ===== rtl/sgp_pkg.sv =====
// ----------------------------------------------------------------------------
// sgp_pkg
// Shared types and constants of the skyline grid placement block.
// ----------------------------------------------------------------------------
package sgp_pkg;

	// Configuration port layout.
	localparam int unsigned CFG_ADDR_BITS = 3;
	localparam int unsigned CFG_DATA_BITS = 32;
	localparam int unsigned COUNT_BITS    = 5;

	// Register index, taken from paddr[2].
	localparam logic REG_COLUMN_COUNT = 1'b0;

	// Reset value of the column count register.
	localparam logic [COUNT_BITS-1:0] COLUMN_COUNT_RESET = 5'd1;

	// Output row fields are 16 bits wide and saturate.
	localparam int unsigned         OUT_ROW_BITS = 16;
	localparam logic [31:0]         OUT_ROW_MAX  = 32'h0000_FFFF;
	localparam int unsigned         OUT_COL_BITS = 4;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_CALC  = 5'b01000,
		ST_WRITE = 5'b10000
	} sgp_state_t;

	// Control from the sequencer to the height store.
	typedef struct packed {
		logic wr_en;
		logic clear_all;
	} sgp_mem_ctl_t;

endpackage

// ===== rtl/sgp_cfg.sv =====
// ----------------------------------------------------------------------------
// sgp_cfg
// APB-style register file holding the column count.
// ----------------------------------------------------------------------------
module sgp_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sgp_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input  logic [sgp_pkg::CFG_DATA_BITS-1:0]   pwdata,
	output logic [sgp_pkg::CFG_DATA_BITS-1:0]   prdata,
	output logic                                pready,
	output logic [sgp_pkg::COUNT_BITS-1:0]      column_count
);
	import sgp_pkg::*;

	logic [COUNT_BITS-1:0] column_count_q;
	logic                  sel_count;

	assign sel_count = (paddr[2] == REG_COLUMN_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= COLUMN_COUNT_RESET;
		end else if (psel && penable && pwrite && sel_count) begin
			column_count_q <= pwdata[COUNT_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_count) begin
			prdata = CFG_DATA_BITS'(column_count_q);
		end
	end

	assign pready       = 1'b1;
	assign column_count = column_count_q;

endmodule

// ===== rtl/sgp_heights.sv =====
// ----------------------------------------------------------------------------
// sgp_heights
// Column height store: one write port, one registered read port, and a
// valid bit per column so that a whole list can be cleared at once.
// ----------------------------------------------------------------------------
module sgp_heights #(
	parameter int unsigned MAX_COLUMNS = 16,
	parameter int unsigned ROW_BITS    = 16,
	parameter int unsigned IDX_BITS    = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sgp_pkg::sgp_mem_ctl_t       mem_ctl,
	input  logic [IDX_BITS-1:0]         wr_addr,
	input  logic [ROW_BITS-1:0]         wr_data,
	input  logic [IDX_BITS-1:0]         rd_addr,
	output logic [ROW_BITS-1:0]         rd_height
);
	import sgp_pkg::*;

	logic [ROW_BITS-1:0]    height_mem [MAX_COLUMNS];
	logic [MAX_COLUMNS-1:0] col_valid_q;
	logic [ROW_BITS-1:0]    rd_data_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			height_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= height_mem[rd_addr];
	end

	// A column that was never written since the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (mem_ctl.clear_all) begin
				col_valid_q <= '0;
			end else if (mem_ctl.wr_en) begin
				col_valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= col_valid_q[rd_addr];
		end
	end

	assign rd_height = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== rtl/sgp_seq.sv =====
// ----------------------------------------------------------------------------
// sgp_seq
// Placement sequencer: scans every window through one shared max/compare unit,
// picks the lowest window, emits the result and raises its columns if not last.
// ----------------------------------------------------------------------------
module sgp_seq #(
	parameter int unsigned MAX_COLUMNS = 16,
	parameter int unsigned ROW_BITS    = 16,
	parameter int unsigned IDX_BITS    = 4,
	parameter int unsigned CNT_BITS    = 5
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [sgp_pkg::COUNT_BITS-1:0]        column_count,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [7:0]                            row_span,
	input  logic [7:0]                            col_span,
	input  logic                                  last_item,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [sgp_pkg::OUT_ROW_BITS-1:0]      placed_row,
	output logic [sgp_pkg::OUT_COL_BITS-1:0]      placed_column,
	output logic [sgp_pkg::OUT_ROW_BITS-1:0]      total_rows,
	output sgp_pkg::sgp_mem_ctl_t                 mem_ctl,
	output logic [IDX_BITS-1:0]                   rd_addr,
	output logic [IDX_BITS-1:0]                   wr_addr,
	output logic [ROW_BITS-1:0]                   wr_data,
	input  logic [ROW_BITS-1:0]                   rd_height
);
	import sgp_pkg::*;

	sgp_state_t state_q;

	// Item registers.
	logic [CNT_BITS-1:0] cols_q;
	logic [CNT_BITS-1:0] span_q;
	logic [7:0]          rspan_q;
	logic                last_q;

	// Scan counters on the read side.
	logic [CNT_BITS-1:0] start_q;
	logic [CNT_BITS-1:0] j_q;
	logic [CNT_BITS-1:0] wj_q;

	// Tags that travel with the registered read.
	logic                tag_vld_s1;
	logic                tag_first_s1;
	logic                tag_last_s1;
	logic [CNT_BITS-1:0] tag_start_s1;

	// Compare unit state.
	logic [ROW_BITS-1:0] wmax_q;
	logic [ROW_BITS-1:0] best_row_q;
	logic [IDX_BITS-1:0] best_col_q;
	logic                have_q;
	logic [ROW_BITS-1:0] tallest_q;
	logic [ROW_BITS-1:0] top_q;

	// Output register.
	logic                    out_valid_q;
	logic [OUT_ROW_BITS-1:0] placed_row_q;
	logic [OUT_COL_BITS-1:0] placed_column_q;
	logic [OUT_ROW_BITS-1:0] total_rows_q;

	logic [CNT_BITS-1:0] cols_eff;
	logic [CNT_BITS-1:0] span_eff;
	logic                accept;
	logic                win_end;
	logic                last_start;
	logic                wr_end;
	logic [ROW_BITS-1:0] cur_max;
	logic [ROW_BITS:0]   top_sum;
	logic [ROW_BITS-1:0] top_sat;
	logic [ROW_BITS-1:0] tallest_next;
	logic [31:0]         row_ext;
	logic [31:0]         tall_ext;
	logic [31:0]         col_ext;
	logic                load;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);

	// Clamp the column count and the column span.
	always_comb begin
		if (column_count == '0) begin
			cols_eff = CNT_BITS'(1);
		end else if (32'(column_count) > MAX_COLUMNS) begin
			cols_eff = CNT_BITS'(MAX_COLUMNS);
		end else begin
			cols_eff = CNT_BITS'(column_count);
		end
		if (col_span == '0) begin
			span_eff = CNT_BITS'(1);
		end else if (32'(col_span) > 32'(cols_eff)) begin
			span_eff = cols_eff;
		end else begin
			span_eff = CNT_BITS'(col_span);
		end
	end

	assign win_end    = ({1'b0, j_q} == ({1'b0, start_q} + {1'b0, span_q} - 1'b1));
	assign last_start = (({1'b0, start_q} + {1'b0, span_q}) == {1'b0, cols_q});
	assign wr_end     = ({1'b0, wj_q} ==
		({1'b0, CNT_BITS'(best_col_q)} + {1'b0, span_q} - 1'b1));

	// Shared max/compare unit, one column height per cycle.
	assign cur_max = (tag_first_s1 || (rd_height > wmax_q)) ? rd_height : wmax_q;

	assign top_sum      = {1'b0, best_row_q} + (ROW_BITS + 1)'(rspan_q);
	assign top_sat      = top_sum[ROW_BITS] ? '1 : top_sum[ROW_BITS-1:0];
	assign tallest_next = (top_sat > tallest_q) ? top_sat : tallest_q;
	assign row_ext      = 32'(best_row_q);
	assign tall_ext     = 32'(tallest_next);
	assign col_ext      = 32'(best_col_q);

	assign load = (state_q == ST_CALC) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tag_vld_s1  <= 1'b0;
			have_q      <= 1'b0;
			tallest_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			tag_vld_s1 <= (state_q == ST_SCAN);

			if (tag_vld_s1 && tag_last_s1 && (!have_q || (cur_max < best_row_q))) begin
				have_q <= 1'b1;
			end

			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						have_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (win_end && last_start) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (load) begin
						// The last item of a list clears the skyline after its result.
						if (last_q) begin
							tallest_q <= '0;
							state_q   <= ST_IDLE;
						end else begin
							tallest_q <= tallest_next;
							state_q   <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					if (wr_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cols_q  <= cols_eff;
			span_q  <= span_eff;
			rspan_q <= row_span;
			last_q  <= last_item;
			start_q <= '0;
			j_q     <= '0;
		end else if (state_q == ST_SCAN) begin
			if (win_end) begin
				start_q <= start_q + 1'b1;
				j_q     <= start_q + 1'b1;
			end else begin
				j_q <= j_q + 1'b1;
			end
		end

		tag_first_s1 <= (j_q == start_q);
		tag_last_s1  <= win_end;
		tag_start_s1 <= start_q;

		if (tag_vld_s1) begin
			wmax_q <= cur_max;
			if (tag_last_s1 && (!have_q || (cur_max < best_row_q))) begin
				best_row_q <= cur_max;
				best_col_q <= tag_start_s1[IDX_BITS-1:0];
			end
		end

		if (load) begin
			top_q           <= top_sat;
			wj_q            <= CNT_BITS'(best_col_q);
			placed_row_q    <= (row_ext > OUT_ROW_MAX) ? OUT_ROW_BITS'(OUT_ROW_MAX)
				: row_ext[OUT_ROW_BITS-1:0];
			placed_column_q <= col_ext[OUT_COL_BITS-1:0];
			total_rows_q    <= (tall_ext > OUT_ROW_MAX) ? OUT_ROW_BITS'(OUT_ROW_MAX)
				: tall_ext[OUT_ROW_BITS-1:0];
		end else if (state_q == ST_WRITE) begin
			wj_q <= wj_q + 1'b1;
		end
	end

	assign mem_ctl.wr_en     = (state_q == ST_WRITE);
	assign mem_ctl.clear_all = load && last_q;
	assign rd_addr           = j_q[IDX_BITS-1:0];
	assign wr_addr           = wj_q[IDX_BITS-1:0];
	assign wr_data           = top_q;

	assign out_valid     = out_valid_q;
	assign placed_row    = placed_row_q;
	assign placed_column = placed_column_q;
	assign total_rows    = total_rows_q;

endmodule

// ===== rtl/skyline_grid_placement_core.sv =====
// ----------------------------------------------------------------------------
// skyline_grid_placement_core
// Skyline placement of grid items into a grid of configurable width.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_stall    row_span, col_span, last_item
//   out      output     out_valid/out_stall  placed_row, placed_column, total_rows
//   cfg      input      APB psel/penable     column_count at address 0
//
// With C effective columns and a span of S, an item scans C-S+1 windows
// of S columns, one column read per cycle through the height store's read
// port, passes through DRAIN and CALC, then writes its S raised columns (no
// writes for the last item of a list). The input stalls for the whole placement.
// Reset clears all heights at once through per-column valid bits.
// A stalled result holds the sequencer only at its final result load.
// ----------------------------------------------------------------------------
module skyline_grid_placement_core #(
	parameter int unsigned MAX_COLUMNS = 16,
	parameter int unsigned ROW_BITS    = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sgp_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input  logic [sgp_pkg::CFG_DATA_BITS-1:0]   pwdata,
	output logic [sgp_pkg::CFG_DATA_BITS-1:0]   prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          row_span,
	input  logic [7:0]                          col_span,
	input  logic                                last_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sgp_pkg::OUT_ROW_BITS-1:0]    placed_row,
	output logic [sgp_pkg::OUT_COL_BITS-1:0]    placed_column,
	output logic [sgp_pkg::OUT_ROW_BITS-1:0]    total_rows
);
	import sgp_pkg::*;

	localparam int unsigned IDX_BITS = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int unsigned CNT_BITS = $clog2(MAX_COLUMNS + 1);

	logic [COUNT_BITS-1:0] column_count;
	sgp_mem_ctl_t          mem_ctl;
	logic [IDX_BITS-1:0]   rd_addr;
	logic [IDX_BITS-1:0]   wr_addr;
	logic [ROW_BITS-1:0]   wr_data;
	logic [ROW_BITS-1:0]   rd_height;

	sgp_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.column_count (column_count)
	);

	sgp_heights #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.ROW_BITS    (ROW_BITS),
		.IDX_BITS    (IDX_BITS)
	) u_heights (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_ctl   (mem_ctl),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.rd_height (rd_height)
	);

	sgp_seq #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.ROW_BITS    (ROW_BITS),
		.IDX_BITS    (IDX_BITS),
		.CNT_BITS    (CNT_BITS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.column_count  (column_count),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.row_span      (row_span),
		.col_span      (col_span),
		.last_item     (last_item),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.placed_row    (placed_row),
		.placed_column (placed_column),
		.total_rows    (total_rows),
		.mem_ctl       (mem_ctl),
		.rd_addr       (rd_addr),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_height     (rd_height)
	);

endmodule

// ===== rtl/sgp_checker.sv =====
// ----------------------------------------------------------------------------
// sgp_checker
// Port-level checks of the skyline placement core, bound to its top level.
// ----------------------------------------------------------------------------
module sgp_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [sgp_pkg::OUT_ROW_BITS-1:0]    placed_row,
	input  logic [sgp_pkg::OUT_ROW_BITS-1:0]    total_rows
);
	import sgp_pkg::*;

	// An accepted item keeps the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after an accepted item");

	// A new result only appears while an item is being placed.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no item in progress");

	// The total height never lies below the row of the item just placed.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (placed_row <= total_rows))
		else $error("placed row above total rows");

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(placed_row) && $stable(total_rows)))
		else $error("stalled result changed");

endmodule

bind skyline_grid_placement_core sgp_checker u_sgp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.placed_row (placed_row),
	.total_rows (total_rows)
);
